FILE: hdl/utu_pkg.sv
package utu_pkg;

	// width of the count fields on the result side
	localparam int OUT_COUNT_W = 32;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one classified input word, as handed from front to back
	typedef struct packed {
		logic [3:0][7:0]         char_bytes;  // byte 0 goes out first
		logic [2:0]              nbytes;      // character bytes, 0 to 4
		logic                    term;        // append terminating zero byte
		logic [OUT_COUNT_W-1:0]  chars;       // character count snapshot
		logic [OUT_COUNT_W-1:0]  ascii;       // ascii prefix snapshot
	} cmd_t;

endpackage

FILE: hdl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder. Each word pushed is one UTF-16 code unit; each word popped
// is one UTF-8 byte with its flags and the character and leading-ASCII counts that hold
// after the unit that produced it. The front classifies a unit and updates the surrogate,
// halt and count state in the cycle it is pushed, then queues a command of up to four
// bytes plus an optional terminator in a four-entry queue. The back sends one byte per
// cycle through an output register while the result side pops; a unit makes
// no bytes when skipped or held, one for ASCII, two or three for other BMP units, four
// for a surrogate pair, one more with the terminator; that byte serializer sets the rate.
// A byte passes through a queue slot and then the output register before it shows.
module utf16_to_utf8_transcoder_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [15:0]                     code_unit,
	input  logic                            end_of_input,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_byte,
	output logic                            run_last,
	output logic                            string_end,
	output logic [utu_pkg::OUT_COUNT_W-1:0] chars_total,
	output logic [utu_pkg::OUT_COUNT_W-1:0] ascii_run
);
	import utu_pkg::*;

	logic accept;
	logic cmd_valid;
	cmd_t cmd;
	cmd_t head;
	logic head_empty;
	logic head_pop;

	assign accept = push && !full;

	// classify and count
	utu_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.code_unit   (code_unit),
		.end_of_input(end_of_input),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd)
	);

	// commands waiting for the serializer
	utu_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (cmd_valid),
		.wr_cmd(cmd),
		.full  (full),
		.rd_en (head_pop),
		.rd_cmd(head),
		.empty (head_empty)
	);

	// byte serializer
	utu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end),
		.chars_total(chars_total),
		.ascii_run  (ascii_run)
	);

endmodule

FILE: hdl/utu_front.sv
module utu_front #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [15:0]   code_unit,
	input  logic          end_of_input,
	output logic          cmd_valid,
	output utu_pkg::cmd_t cmd
);
	import utu_pkg::*;

	localparam logic [5:0]  LEAD_TAG       = 6'b110110;
	localparam logic [5:0]  TRAIL_TAG      = 6'b110111;
	localparam logic [15:0] BOM_UNIT       = 16'hFEFF;
	localparam logic [15:0] NONCHAR_FFFE   = 16'hFFFE;
	localparam logic [15:0] NONCHAR_FFFF   = 16'hFFFF;
	localparam logic [15:0] TWO_BYTE_MIN   = 16'h0080;
	localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	logic [9:0]             held_lead_q;
	logic                   lead_valid_q;
	logic                   halted_q;
	logic [COUNT_WIDTH-1:0] chars_q;
	logic [COUNT_WIDTH-1:0] ascii_q;

	logic [9:0]             held_lead_d;
	logic                   lead_valid_d;
	logic                   halted_d;
	logic [COUNT_WIDTH-1:0] chars_d;
	logic [COUNT_WIDTH-1:0] ascii_d;

	logic                   is_lead;
	logic                   is_trail;
	logic                   is_skip;
	logic [20:0]            cp;
	logic                   count_en;
	logic                   count_ascii;
	logic [COUNT_WIDTH-1:0] chars_inc;
	logic [COUNT_WIDTH-1:0] ascii_inc;
	logic [COUNT_WIDTH+OUT_COUNT_W-1:0] chars_ext;
	logic [COUNT_WIDTH+OUT_COUNT_W-1:0] ascii_ext;
	logic [3:0][7:0]        char_bytes;
	logic [2:0]             nbytes;
	logic                   term;

	// unit classification
	assign is_lead  = (code_unit[15:10] == LEAD_TAG);
	assign is_trail = (code_unit[15:10] == TRAIL_TAG);
	assign is_skip  = is_trail || (code_unit == BOM_UNIT) ||
		(code_unit == NONCHAR_FFFE) || (code_unit == NONCHAR_FFFF);
	assign cp = {1'b0, held_lead_q, code_unit[9:0]} + SUPP_BASE;

	// saturating counter increments
	assign chars_inc = (&chars_q) ? chars_q : chars_q + CNT_ONE;
	assign ascii_inc = (&ascii_q) ? ascii_q : ascii_q + CNT_ONE;

	// next state and command for the word on the input
	always_comb begin
		held_lead_d  = held_lead_q;
		lead_valid_d = lead_valid_q;
		halted_d     = halted_q;
		count_en     = 1'b0;
		count_ascii  = 1'b0;
		char_bytes   = '0;
		nbytes       = 3'd0;
		term         = end_of_input;
		if (!halted_q) begin
			held_lead_d  = '0;
			lead_valid_d = 1'b0;
			if (lead_valid_q && is_trail) begin
				char_bytes[0] = {5'b11110, cp[20:18]};
				char_bytes[1] = {2'b10, cp[17:12]};
				char_bytes[2] = {2'b10, cp[11:6]};
				char_bytes[3] = {2'b10, cp[5:0]};
				nbytes        = 3'd4;
				count_en      = 1'b1;
			end else if (code_unit == '0) begin
				halted_d = 1'b1;
			end else if (is_skip) begin
				// skipped unit, only drops a held lead
			end else if (is_lead) begin
				held_lead_d  = code_unit[9:0];
				lead_valid_d = 1'b1;
			end else if (code_unit >= THREE_BYTE_MIN) begin
				char_bytes[0] = {4'b1110, code_unit[15:12]};
				char_bytes[1] = {2'b10, code_unit[11:6]};
				char_bytes[2] = {2'b10, code_unit[5:0]};
				nbytes        = 3'd3;
				count_en      = 1'b1;
			end else if (code_unit >= TWO_BYTE_MIN) begin
				char_bytes[0] = {3'b110, code_unit[10:6]};
				char_bytes[1] = {2'b10, code_unit[5:0]};
				nbytes        = 3'd2;
				count_en      = 1'b1;
			end else begin
				char_bytes[0] = {1'b0, code_unit[6:0]};
				nbytes        = 3'd1;
				count_en      = 1'b1;
				count_ascii   = 1'b1;
			end
		end
		if (end_of_input) begin
			held_lead_d  = '0;
			lead_valid_d = 1'b0;
			halted_d     = 1'b0;
		end
	end

	// counters after this word
	always_comb begin
		chars_d = chars_q;
		ascii_d = ascii_q;
		if (count_en) begin
			chars_d = chars_inc;
			if (count_ascii && (ascii_q == chars_q)) begin
				ascii_d = ascii_inc;
			end
		end
	end

	// snapshots trimmed or extended to the result width
	assign chars_ext = {{OUT_COUNT_W{1'b0}}, chars_d};
	assign ascii_ext = {{OUT_COUNT_W{1'b0}}, ascii_d};

	// command fields in struct order
	assign cmd = {char_bytes, nbytes, term,
		chars_ext[OUT_COUNT_W-1:0], ascii_ext[OUT_COUNT_W-1:0]};

	assign cmd_valid = accept && ((nbytes != 3'd0) || end_of_input);

	// conversion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q  <= '0;
			lead_valid_q <= 1'b0;
			halted_q     <= 1'b0;
			chars_q      <= '0;
			ascii_q      <= '0;
		end else if (accept) begin
			held_lead_q  <= held_lead_d;
			lead_valid_q <= lead_valid_d;
			halted_q     <= halted_d;
			chars_q      <= chars_d;
			ascii_q      <= ascii_d;
		end
	end

endmodule

FILE: hdl/utu_queue.sv
module utu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  utu_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output utu_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import utu_pkg::*;

	localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W+1)'(QUEUE_DEPTH);
	localparam logic [QPTR_W:0] CNT_ONE   = {{QPTR_W{1'b0}}, 1'b1};
	localparam logic [QPTR_W-1:0] PTR_ONE = {{(QPTR_W-1){1'b0}}, 1'b1};

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (count_q == DEPTH_CNT);
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = slot_q[rd_ptr_q];

	// command storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_ONE;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_ONE;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_ONE;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

FILE: hdl/utu_back.sv
module utu_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  utu_pkg::cmd_t                   head,
	input  logic                            head_empty,
	output logic                            head_pop,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_byte,
	output logic                            run_last,
	output logic                            string_end,
	output logic [utu_pkg::OUT_COUNT_W-1:0] chars_total,
	output logic [utu_pkg::OUT_COUNT_W-1:0] ascii_run
);
	import utu_pkg::*;

	logic [2:0]             idx_q;
	logic                   out_valid_q;
	logic [7:0]             byte_q;
	logic                   last_q;
	logic                   end_q;
	logic [OUT_COUNT_W-1:0] chars_q;
	logic [OUT_COUNT_W-1:0] ascii_q;

	logic       load;
	logic [2:0] total;
	logic       is_last;
	logic       is_term;
	logic [7:0] next_byte;

	// pick the byte of the head command at the current index
	assign total     = head.nbytes + {2'b00, head.term};
	assign is_last   = (idx_q == total - 3'd1);
	assign is_term   = (idx_q >= head.nbytes);
	assign next_byte = is_term ? 8'h00 : head.char_bytes[idx_q[1:0]];

	assign load     = !head_empty && (!out_valid_q || pop);
	assign head_pop = load && is_last;

	// byte index within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= next_byte;
			last_q  <= is_last;
			end_q   <= is_term;
			chars_q <= head.chars;
			ascii_q <= head.ascii;
		end
	end

	assign empty       = !out_valid_q;
	assign out_byte    = byte_q;
	assign run_last    = last_q;
	assign string_end  = end_q;
	assign chars_total = chars_q;
	assign ascii_run   = ascii_q;

endmodule

FILE: sim/utu_checker.sv
module utu_checker #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic                            full,
	input  logic [15:0]                     code_unit,
	input  logic                            end_of_input,
	input  logic                            empty,
	input  logic                            pop,
	input  logic [7:0]                      out_byte,
	input  logic                            run_last,
	input  logic                            string_end,
	input  logic [utu_pkg::OUT_COUNT_W-1:0] chars_total,
	input  logic [utu_pkg::OUT_COUNT_W-1:0] ascii_run,
	output int                              fail_count,
	output int                              pending,
	output int                              words_checked
);
	import utu_pkg::*;

	localparam logic [15:0] LEAD_FIRST     = 16'hD800;
	localparam logic [15:0] TRAIL_FIRST    = 16'hDC00;
	localparam logic [15:0] TRAIL_LAST     = 16'hDFFF;
	localparam logic [15:0] BYTE_ORDER_MK  = 16'hFEFF;
	localparam logic [15:0] NONCHAR_FFFE   = 16'hFFFE;
	localparam logic [15:0] NONCHAR_FFFF   = 16'hFFFF;
	localparam logic [15:0] TWO_BYTE_MIN   = 16'h0080;
	localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef struct {
		logic [7:0]             octet;
		logic                   last;
		logic                   term;
		logic [OUT_COUNT_W-1:0] chars;
		logic [OUT_COUNT_W-1:0] ascii;
	} utf8_word_t;

	// words still owed by the block, oldest first
	utf8_word_t expected_bytes[$];
	utf8_word_t oldest;

	// mirror of the transcoder state
	logic [9:0]             held_lead;
	logic                   lead_held;
	logic                   halted;
	logic [COUNT_WIDTH-1:0] char_count;
	logic [COUNT_WIDTH-1:0] ascii_prefix;
	int                     fails;
	int                     checked;

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	// ascii prefix only grows while no multibyte character has been seen
	task automatic count_char(input logic is_ascii);
		if (is_ascii && ascii_prefix == char_count)
			ascii_prefix = bump(ascii_prefix);
		char_count = bump(char_count);
	endtask

	// work out the words one accepted code unit yields
	task automatic encode_unit(input logic [15:0] u, input logic eoi);
		logic [7:0]  seq [5];
		logic [20:0] cp;
		logic        is_lead;
		logic        is_trail;
		utf8_word_t  w;
		int          n;
		n = 0;
		is_lead  = (u >= LEAD_FIRST && u < TRAIL_FIRST);
		is_trail = (u >= TRAIL_FIRST && u <= TRAIL_LAST);
		if (!halted) begin
			if (lead_held && is_trail) begin
				// surrogate pair becomes a 4-byte sequence
				cp = {1'b0, held_lead, u[9:0]} + SUPP_BASE;
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
				n = 4;
				count_char(1'b0);
				lead_held = 1'b0;
				held_lead = '0;
			end else begin
				// anything but a trail drops a held lead
				lead_held = 1'b0;
				held_lead = '0;
				if (u == 16'h0000) begin
					halted = 1'b1;
				end else if (is_trail || u == BYTE_ORDER_MK || u == NONCHAR_FFFE ||
						u == NONCHAR_FFFF) begin
					// skipped, nothing emitted
				end else if (is_lead) begin
					held_lead = u[9:0];
					lead_held = 1'b1;
				end else if (u >= THREE_BYTE_MIN) begin
					seq[0] = {4'b1110, u[15:12]};
					seq[1] = {2'b10, u[11:6]};
					seq[2] = {2'b10, u[5:0]};
					n = 3;
					count_char(1'b0);
				end else if (u >= TWO_BYTE_MIN) begin
					seq[0] = {3'b110, u[10:6]};
					seq[1] = {2'b10, u[5:0]};
					n = 2;
					count_char(1'b0);
				end else begin
					seq[0] = u[7:0];
					n = 1;
					count_char(1'b1);
				end
			end
		end
		// end of string: terminator and clean surrogate/halt state
		if (eoi) begin
			seq[n] = 8'h00;
			n++;
			held_lead = '0;
			lead_held = 1'b0;
			halted    = 1'b0;
		end
		for (int k = 0; k < n; k++) begin
			w.octet = seq[k];
			w.last  = (k == n - 1);
			w.term  = eoi && (k == n - 1);
			w.chars = char_count[OUT_COUNT_W-1:0];
			w.ascii = ascii_prefix[OUT_COUNT_W-1:0];
			expected_bytes.push_back(w);
		end
	endtask

	// predict on accepted units, compare on accepted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes.delete();
			held_lead     = '0;
			lead_held     = 1'b0;
			halted        = 1'b0;
			char_count    = '0;
			ascii_prefix  = '0;
			fails         = 0;
			checked       = 0;
			fail_count    <= 0;
			pending       <= 0;
			words_checked <= 0;
		end else begin
			if (push && !full)
				encode_unit(code_unit, end_of_input);
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected word: out_byte %h string_end %b", out_byte, string_end);
					fails++;
				end else begin
					oldest = expected_bytes.pop_front();
					checked++;
					if (out_byte !== oldest.octet) begin
						$error("out_byte: expected %h, got %h", oldest.octet, out_byte);
						fails++;
					end
					if (run_last !== oldest.last) begin
						$error("run_last: expected %b, got %b", oldest.last, run_last);
						fails++;
					end
					if (string_end !== oldest.term) begin
						$error("string_end: expected %b, got %b", oldest.term, string_end);
						fails++;
					end
					if (chars_total !== oldest.chars) begin
						$error("chars_total: expected %0d, got %0d", oldest.chars, chars_total);
						fails++;
					end
					if (ascii_run !== oldest.ascii) begin
						$error("ascii_run: expected %0d, got %0d", oldest.ascii, ascii_run);
						fails++;
					end
				end
			end
			fail_count    <= fails;
			pending       <= expected_bytes.size();
			words_checked <= checked;
		end
	end

endmodule

FILE: sim/tb.sv
module tb;
	import utu_pkg::*;

	localparam int RANDOM_UNITS = 250;
	localparam int LONG_HOLD    = 80;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic [15:0]            code_unit;
	logic                   end_of_input;
	logic                   empty;
	logic                   pop;
	logic [7:0]             out_byte;
	logic                   run_last;
	logic                   string_end;
	logic [OUT_COUNT_W-1:0] chars_total;
	logic [OUT_COUNT_W-1:0] ascii_run;

	int fail_count;
	int pending;
	int words_checked;
	int units_sent;
	int directed_units;
	int strings_sent;
	int burst_left;
	int full_stalls;
	bit hold_req;

	utf16_to_utf8_transcoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.code_unit    (code_unit),
		.end_of_input (end_of_input),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.string_end   (string_end),
		.chars_total  (chars_total),
		.ascii_run    (ascii_run)
	);

	utu_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.code_unit     (code_unit),
		.end_of_input  (end_of_input),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.run_last      (run_last),
		.string_end    (string_end),
		.chars_total   (chars_total),
		.ascii_run     (ascii_run),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("utf16_to_utf8_transcoder_unit verification failed");
		$finish;
	end

	// cycles the input side was held off by a full queue
	always @(posedge clk)
		if (arst_n && push && full)
			full_stalls++;

	// offer one unit, wait for it to be taken, then maybe open a gap
	task automatic push_unit(input logic [15:0] cu, input logic eoi);
		int gap;
		@(negedge clk);
		push         <= 1'b1;
		code_unit    <= cu;
		end_of_input <= eoi;
		@(posedge clk);
		while (full)
			@(posedge clk);
		units_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(0, 12);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// stop offering until every owed word has been popped
	task automatic wait_drained;
		@(negedge clk);
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// one string of random well-formed and broken content, last unit ends it
	task automatic push_random_string;
		logic [15:0] units[$];
		int          len;
		int          pick;
		len = $urandom_range(1, 12);
		while (units.size() < len) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				units.push_back(16'($urandom_range(1, 16'h007F)));
			else if (pick < 45)
				units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
			else if (pick < 60)
				units.push_back(($urandom_range(0, 1) == 0) ?
					16'($urandom_range(16'h0800, 16'hD7FF)) :
					16'($urandom_range(16'hE000, 16'hFFFD)));
			else if (pick < 80) begin
				units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
				units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
			end else if (pick < 85)
				units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
			else if (pick < 90)
				units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
			else if (pick < 95)
				units.push_back(16'($urandom_range(16'hFFFE, 16'hFFFF)) ^
					(($urandom_range(0, 2) == 0) ? 16'h0100 : 16'h0000));
			else if (pick < 98)
				units.push_back(16'h0000);
			else
				units.push_back(16'($urandom_range(0, 16'hFFFF)));
		end
		foreach (units[i])
			push_unit(units[i], i == units.size() - 1);
		strings_sent++;
	endtask

	// result side: own stall pattern plus one long hold-off on request
	initial begin
		int mode;
		int len;
		pop      = 1'b0;
		hold_req = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				pop <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len  = $urandom_range(8, 40);
				repeat (len) begin
					@(negedge clk);
					case (mode)
						0:       pop <= 1'b1;
						1:       pop <= 1'($urandom_range(0, 1));
						default: pop <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		code_unit    = '0;
		end_of_input = 1'b0;
		units_sent   = 0;
		strings_sent = 0;
		burst_left   = 0;
		full_stalls  = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: size classes and their edges
		push_unit(16'h0041, 1'b0);
		push_unit(16'h007F, 1'b0);
		push_unit(16'h0001, 1'b0);
		push_unit(16'h0080, 1'b0);
		push_unit(16'h07FF, 1'b0);
		push_unit(16'h0800, 1'b0);
		push_unit(16'hFFFD, 1'b0);
		// surrogate pairs at both corners
		push_unit(16'hD800, 1'b0);
		push_unit(16'hDC00, 1'b0);
		push_unit(16'hDBFF, 1'b0);
		push_unit(16'hDFFF, 1'b0);
		// lone trail and the skipped specials
		push_unit(16'hDC00, 1'b0);
		push_unit(16'hFEFF, 1'b0);
		push_unit(16'hFFFE, 1'b0);
		push_unit(16'hFFFF, 1'b0);
		// lead dropped by a plain unit, lead replaced by another lead
		push_unit(16'hD83D, 1'b0);
		push_unit(16'h0041, 1'b0);
		push_unit(16'hD800, 1'b0);
		push_unit(16'hDBFF, 1'b0);
		push_unit(16'hDE00, 1'b0);
		// lead still held at the end of the string
		push_unit(16'hD800, 1'b1);
		// zero unit halts until the end, halted end emits only the terminator
		push_unit(16'h00E9, 1'b0);
		push_unit(16'h0000, 1'b0);
		push_unit(16'h4E2D, 1'b0);
		push_unit(16'hD800, 1'b1);
		push_unit(16'h0000, 1'b1);
		directed_units = units_sent;
		wait_drained();

		// random strings; the receiver takes one long break early on
		hold_req = 1'b1;
		while (units_sent - directed_units < RANDOM_UNITS) begin
			push_random_string();
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
		wait_drained();
		repeat (8) @(posedge clk);

		$display("%0d code units in %0d random strings plus %0d directed units, %0d bytes checked",
			units_sent - directed_units, strings_sent, directed_units, words_checked);
		$display("input held off by a full queue for %0d cycles", full_stalls);
		if (fail_count == 0)
			$display("utf16_to_utf8_transcoder_unit verification clean");
		else
			$display("utf16_to_utf8_transcoder_unit verification failed");
		$finish;
	end

endmodule
